/* hdl/uuidp_pkg.sv */
// uuidp_pkg: shared types, character constants and status codes for the uuid text parser
// used by uuidp_forms, uuidp_result_buf and uuid_text_parser_core; no dependencies
package uuidp_pkg;

    localparam int CountWidth = 6;

    localparam logic [CountWidth-1:0] PLAIN_LEN  = 6'd32;
    localparam logic [CountWidth-1:0] HYPHEN_LEN = 6'd36;
    localparam logic [CountWidth-1:0] BRACE_LEN  = 6'd38;
    localparam logic [CountWidth-1:0] COUNT_MAX  = 6'd39;

    localparam logic [7:0] CH_HYPHEN  = 8'h2D;  // '-'
    localparam logic [7:0] CH_LBRACE  = 8'h7B;  // '{'
    localparam logic [7:0] CH_RBRACE  = 8'h7D;  // '}'
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'hA;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CHR = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [1:0]  status;
    } uuidp_result_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.val = 4'h0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d.val = 4'(c - CH_DIGIT_0);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d.val = HEX_TEN + 4'(c - CH_LOWER_A);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d.val = HEX_TEN + 4'(c - CH_UPPER_A);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

/* hdl/uuidp_forms.sv */
// uuidp_forms: character counter and the three form checkers with their digit shift registers
// depends on uuidp_pkg; produces the result of a string on its final character
module uuidp_forms
    import uuidp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    char_in,
    input  logic          last_in,
    output uuidp_result_t result
);

    logic [CountWidth-1:0] count_reg, count_next;
    logic                  plain_ok_reg, plain_ok_next;
    logic                  hyphen_ok_reg, hyphen_ok_next;
    logic                  brace_ok_reg, brace_ok_next;
    logic [127:0]          plain_nib_reg, plain_nib_next;
    logic [127:0]          hyphen_nib_reg, hyphen_nib_next;
    logic [127:0]          brace_nib_reg, brace_nib_next;

    hex_digit_t digit;
    logic       hy_mark;
    logic       br_mark;
    logic [7:0] br_mark_char;
    logic       sel_ok;
    logic [127:0] sel_nib;

    always_comb begin
        digit = hex_decode(char_in);

        hy_mark = (count_reg == 6'd8) || (count_reg == 6'd13) ||
                  (count_reg == 6'd18) || (count_reg == 6'd23);

        br_mark      = 1'b1;
        br_mark_char = CH_HYPHEN;
        if (count_reg == 6'd0) begin
            br_mark_char = CH_LBRACE;
        end else if (count_reg == BRACE_LEN - 6'd1) begin
            br_mark_char = CH_RBRACE;
        end else begin
            br_mark = (count_reg == 6'd9) || (count_reg == 6'd14) ||
                      (count_reg == 6'd19) || (count_reg == 6'd24);
        end

        plain_ok_next   = plain_ok_reg;
        plain_nib_next  = plain_nib_reg;
        hyphen_ok_next  = hyphen_ok_reg;
        hyphen_nib_next = hyphen_nib_reg;
        brace_ok_next   = brace_ok_reg;
        brace_nib_next  = brace_nib_reg;

        if (count_reg < PLAIN_LEN) begin
            if (digit.ok) begin
                plain_nib_next = {plain_nib_reg[123:0], digit.val};
            end else begin
                plain_ok_next = 1'b0;
            end
        end

        if (count_reg < HYPHEN_LEN) begin
            if (hy_mark) begin
                if (char_in != CH_HYPHEN) begin
                    hyphen_ok_next = 1'b0;
                end
            end else if (digit.ok) begin
                hyphen_nib_next = {hyphen_nib_reg[123:0], digit.val};
            end else begin
                hyphen_ok_next = 1'b0;
            end
        end

        if (count_reg < BRACE_LEN) begin
            if (br_mark) begin
                if (char_in != br_mark_char) begin
                    brace_ok_next = 1'b0;
                end
            end else if (digit.ok) begin
                brace_nib_next = {brace_nib_reg[123:0], digit.val};
            end else begin
                brace_ok_next = 1'b0;
            end
        end

        count_next = (count_reg < COUNT_MAX) ? count_reg + 6'd1 : count_reg;

        // pick the form whose length matches the final count
        sel_ok  = 1'b0;
        sel_nib = '0;
        result.status = ST_BAD_LEN;
        case (count_next)
            PLAIN_LEN: begin
                sel_ok        = plain_ok_next;
                sel_nib       = plain_nib_next;
                result.status = plain_ok_next ? ST_PARSED : ST_BAD_CHR;
            end
            HYPHEN_LEN: begin
                sel_ok        = hyphen_ok_next;
                sel_nib       = hyphen_nib_next;
                result.status = hyphen_ok_next ? ST_PARSED : ST_BAD_CHR;
            end
            BRACE_LEN: begin
                sel_ok        = brace_ok_next;
                sel_nib       = brace_nib_next;
                result.status = brace_ok_next ? ST_PARSED : ST_BAD_CHR;
            end
            default: begin
                sel_ok        = 1'b0;
                sel_nib       = '0;
                result.status = ST_BAD_LEN;
            end
        endcase
        result.uuid_high = sel_ok ? sel_nib[127:64] : 64'd0;
        result.uuid_low  = sel_ok ? sel_nib[63:0]   : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            plain_ok_reg   <= 1'b1;
            hyphen_ok_reg  <= 1'b1;
            brace_ok_reg   <= 1'b1;
            plain_nib_reg  <= '0;
            hyphen_nib_reg <= '0;
            brace_nib_reg  <= '0;
        end else if (fire) begin
            if (last_in) begin
                // string done, back to the start state
                count_reg      <= '0;
                plain_ok_reg   <= 1'b1;
                hyphen_ok_reg  <= 1'b1;
                brace_ok_reg   <= 1'b1;
                plain_nib_reg  <= '0;
                hyphen_nib_reg <= '0;
                brace_nib_reg  <= '0;
            end else begin
                count_reg      <= count_next;
                plain_ok_reg   <= plain_ok_next;
                hyphen_ok_reg  <= hyphen_ok_next;
                brace_ok_reg   <= brace_ok_next;
                plain_nib_reg  <= plain_nib_next;
                hyphen_nib_reg <= hyphen_nib_next;
                brace_nib_reg  <= brace_nib_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("character count beyond saturation");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last_in |=> count_reg == '0 && plain_ok_reg && hyphen_ok_reg && brace_ok_reg)
        else $error("state not cleared after final character");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        result.status != ST_PARSED |-> result.uuid_high == 64'd0 && result.uuid_low == 64'd0)
        else $error("nonzero uuid on failed parse");
`endif

endmodule

/* hdl/uuidp_result_buf.sv */
// uuidp_result_buf: output register with one skid entry for parse results
// depends on uuidp_pkg for the result type
module uuidp_result_buf
    import uuidp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  uuidp_result_t push_data,
    output logic          push_ready,
    output logic          out_valid,
    output uuidp_result_t out_data,
    input  logic          out_ready
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    uuidp_result_t out_data_reg;
    uuidp_result_t skid_data_reg;
    logic          pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push && !out_valid_reg) begin
            out_data_reg <= push_data;
        end
        if (push && out_valid_reg && !pop) begin
            skid_data_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");
`endif

endmodule

/* hdl/uuid_text_parser_core.sv */
// uuid_text_parser_core: top level of the uuid text parser
// depends on uuidp_pkg, uuidp_forms and uuidp_result_buf
//
// Usage:
//   s_ channel: one character per transaction in s_tdata[7:0], s_tlast high on
//   the final character of a string. Plain (32 hex digits), hyphenated (36)
//   and braced (38) forms are checked in parallel, digits in either case.
//   m_ channel: one transaction per string, issued for its final character:
//   bytes 0..7 and 8..15 of the uuid and a status (0 parsed, 1 bad length,
//   2 bad character); the uuid is zero whenever the status is not 0.
//   Pipeline: a final character is held in the input register and its result
//   is registered for m_tvalid (one input register, one result register).
//   Throughput: one character per cycle while s_tready is high; each character
//   passes once through the form checkers between the two registers.
//   Stalls: a result that is not taken waits in the output register while
//   parsing goes on; a second finished result waits in a skid entry, and only
//   a third final character holds s_tready low until m_tready frees space.
//   Reset: aresetn (synchronous, active low) clears the character count, the
//   form flags and all pending transactions; the next character starts a string.
module uuid_text_parser_core
    import uuidp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] character
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // [63:0] uuid_high, [127:64] uuid_low, [129:128] status
);

    logic          in_valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic          advance;
    logic          buf_ready;
    uuidp_result_t stage_result;
    uuidp_result_t out_result;

    // a non-final character never waits on the result side
    assign advance  = in_valid_reg && (!last_reg || buf_ready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    uuidp_forms u_forms (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .char_in (char_reg),
        .last_in (last_reg),
        .result  (stage_result)
    );

    uuidp_result_buf u_result_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance && last_reg),
        .push_data  (stage_result),
        .push_ready (buf_ready),
        .out_valid  (m_tvalid),
        .out_data   (out_result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {6'd0, out_result.status, out_result.uuid_low, out_result.uuid_high};

endmodule

/* test/tb_uuid_text_parser_core.sv */
// tb_uuid_text_parser_core: self-checking testbench for the uuid text parser core
// streams uuid strings (directed table, then random well-formed, corrupted and noise
// strings) and checks every result against the directed table or a local parser model; needs uuidp_pkg and the rtl
module tb_uuid_text_parser_core;
    import uuidp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ResetCycles  = 10;
    localparam int          RandomChars  = 1200;
    localparam int          MinResults   = 40;
    localparam int          HoldCycles   = 400;
    localparam int          HoldAfter    = 12;
    localparam int          DrainCycles  = 8;
    localparam int unsigned CycleLimit   = 200000;
    localparam logic [1:0]  ST_UNTYPED   = 2'd3;   // row result comes from the parser model
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          DirRows      = 17;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    uuid_text_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // directed strings; rows with a typed status carry their full expected uuid
    string dir_text [DirRows] = '{
        "00000000000000000000000000000000",
        "FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF",
        "{ffffffff-ffff-ffff-ffff-ffffffffffff}",
        "0123456789abcdefABCDEF0123456789",
        "12345678-9abc-DEF0-1234-56789abcdef0",
        "{0A1b2C3d-4E5f-6789-aBcD-eF0123456789}",
        "x",
        "0123456789abcdef0123456789abcde",
        "{ffffffff-ffff-ffff-ffff-ffffffffffff}0123456",
        "12345678_9abc-def0-1234-56789abcdef0",
        "{12345678-9abc-def0-1234-56789abcdef0)",
        "[12345678-9abc-def0-1234-56789abcdef0}",
        "\001\377/:@G`g000000000000000000000000",
        "00000000000000000000000000000000",
        "{12345678-9abc-def0-1234-56789abcdef0",
        "0123456789abcdef0123456789abcdef0123",
        "abcdef01-2345-6789-ABCD-EF0123456789"
    };
    // position where a nul character replaces the text, -1 for none
    int dir_nul_pos [DirRows] = '{-1, -1, -1, -1, -1, -1, -1, -1, -1,
                                   -1, -1, -1, -1, 5, -1, -1, -1};
    logic [1:0] dir_status [DirRows] = '{
        ST_PARSED, ST_PARSED, ST_PARSED, ST_PARSED, ST_UNTYPED, ST_UNTYPED,
        ST_BAD_LEN, ST_BAD_LEN, ST_BAD_LEN, ST_BAD_CHR, ST_BAD_CHR, ST_BAD_CHR,
        ST_BAD_CHR, ST_BAD_CHR, ST_BAD_LEN, ST_BAD_CHR, ST_UNTYPED
    };
    logic [63:0] dir_high [DirRows] = '{
        64'h0, ALL_ONES, ALL_ONES, 64'h0123_4567_89ab_cdef, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
    };
    logic [63:0] dir_low [DirRows] = '{
        64'h0, ALL_ONES, ALL_ONES, 64'habcd_ef01_2345_6789, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
    };

    // parser model state
    logic [5:0]   seen_count;
    bit           plain_fits;
    bit           hyphen_fits;
    bit           brace_fits;
    logic [127:0] plain_digits;
    logic [127:0] hyphen_digits;
    logic [127:0] brace_digits;

    uuidp_result_t expected_uuids[$];
    logic [7:0]    text_q[$];

    int unsigned cycle_count;
    int unsigned stall_cycles;
    int unsigned chars_sent;
    int unsigned strings_sent;
    int unsigned results_queued;
    int unsigned results_checked;
    int unsigned errors;
    int unsigned status_seen [3];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_parser();
        seen_count    = '0;
        plain_fits    = 1'b1;
        hyphen_fits   = 1'b1;
        brace_fits    = 1'b1;
        plain_digits  = '0;
        hyphen_digits = '0;
        brace_digits  = '0;
    endfunction

    // one character through all three forms; on the final one returns the uuid and status
    function automatic void parse_char(input logic [7:0] c, input logic is_last,
                                       output bit done, output uuidp_result_t res);
        logic [3:0]   nib;
        bit           is_hex;
        logic [5:0]   pos;
        bit           fits;
        logic [127:0] digits;
        bit           len_ok;
        pos    = seen_count;
        is_hex = 1'b1;
        nib    = 4'h0;
        done   = 1'b0;
        res    = '0;
        if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            nib = c[3:0];
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]} || c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            nib = c[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end

        if (pos < PLAIN_LEN) begin
            if (is_hex) plain_digits = {plain_digits[123:0], nib};
            else plain_fits = 1'b0;
        end
        if (pos < HYPHEN_LEN) begin
            if (pos inside {6'd8, 6'd13, 6'd18, 6'd23}) begin
                if (c != CH_HYPHEN) hyphen_fits = 1'b0;
            end else if (is_hex) begin
                hyphen_digits = {hyphen_digits[123:0], nib};
            end else begin
                hyphen_fits = 1'b0;
            end
        end
        if (pos < BRACE_LEN) begin
            if (pos == 6'd0) begin
                if (c != CH_LBRACE) brace_fits = 1'b0;
            end else if (pos == BRACE_LEN - 6'd1) begin
                if (c != CH_RBRACE) brace_fits = 1'b0;
            end else if (pos inside {6'd9, 6'd14, 6'd19, 6'd24}) begin
                if (c != CH_HYPHEN) brace_fits = 1'b0;
            end else if (is_hex) begin
                brace_digits = {brace_digits[123:0], nib};
            end else begin
                brace_fits = 1'b0;
            end
        end
        if (pos < COUNT_MAX) seen_count = pos + 6'd1;

        if (is_last) begin
            done   = 1'b1;
            len_ok = 1'b1;
            fits   = 1'b0;
            digits = '0;
            if (seen_count == PLAIN_LEN) begin
                fits = plain_fits;
                digits = plain_digits;
            end else if (seen_count == HYPHEN_LEN) begin
                fits = hyphen_fits;
                digits = hyphen_digits;
            end else if (seen_count == BRACE_LEN) begin
                fits = brace_fits;
                digits = brace_digits;
            end else begin
                len_ok = 1'b0;
            end
            if (!len_ok) begin
                res.status = ST_BAD_LEN;
            end else if (!fits) begin
                res.status = ST_BAD_CHR;
            end else begin
                res.status    = ST_PARSED;
                res.uuid_high = digits[127:64];
                res.uuid_low  = digits[63:0];
            end
            clear_parser();
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return CH_DIGIT_0 + 8'(v);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] noise_char();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        if (sel < 12) return CH_HYPHEN;
        if (sel == 12) return CH_LBRACE;
        if (sel == 13) return CH_RBRACE;
        return 8'($urandom_range(1, 255));
    endfunction

    // mostly well-formed strings of a random form, some with one damaged character,
    // the rest noise of random length
    task automatic make_random_text();
        int  kind;
        int  form;
        int  len;
        logic [7:0] c;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            form = $urandom_range(0, 2);
            len = (form == 0) ? int'(PLAIN_LEN) : (form == 1) ? int'(HYPHEN_LEN) : int'(BRACE_LEN);
            for (int p = 0; p < len; p++) begin
                c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                if (form == 1 && p inside {8, 13, 18, 23}) c = CH_HYPHEN;
                if (form == 2) begin
                    if (p == 0) c = CH_LBRACE;
                    else if (p == len - 1) c = CH_RBRACE;
                    else if (p inside {9, 14, 19, 24}) c = CH_HYPHEN;
                end
                text_q.push_back(c);
            end
            if (kind >= 70) text_q[$urandom_range(0, len - 1)] = noise_char();
        end else begin
            len = $urandom_range(0, 1) ? $urandom_range(30, 40) : $urandom_range(1, 45);
            for (int p = 0; p < len; p++) text_q.push_back(noise_char());
        end
    endtask

    // sends text_q as one string; typed_res is used instead of the model when typed is set
    task automatic send_text(input bit typed, input uuidp_result_t typed_res);
        int            gap;
        bit            quiet;
        bit            done;
        uuidp_result_t res;
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < text_q.size(); i++) begin
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i];
            s_tlast  <= (i == text_q.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            parse_char(text_q[i], i == text_q.size() - 1, done, res);
            chars_sent++;
            if (done) begin
                expected_uuids.push_back(typed ? typed_res : res);
                results_queued++;
            end
        end
        strings_sent++;
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int            stall;
        bit            held;
        uuidp_result_t want;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && results_checked == HoldAfter) begin
                held = 1'b1;
                stall = HoldCycles;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (expected_uuids.size() == 0) begin
                $error("unexpected result transaction: %h", m_tdata);
                errors++;
            end else begin
                want = expected_uuids.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (m_tdata[63:0] !== want.uuid_high) begin
                    $error("uuid_high: expected %h, got %h", want.uuid_high, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== want.uuid_low) begin
                    $error("uuid_low: expected %h, got %h", want.uuid_low, m_tdata[127:64]);
                    errors++;
                end
                if (m_tdata[129:128] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[129:128]);
                    errors++;
                end
            end
        end
    end

    // cycle limit and input backpressure count
    initial begin
        cycle_count  = 0;
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (s_tvalid && !s_tready) stall_cycles++;
            if (cycle_count > CycleLimit) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, expected_uuids.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        uuidp_result_t typed_res;
        string         s;
        clear_parser();
        chars_sent      = 0;
        strings_sent    = 0;
        results_queued  = 0;
        results_checked = 0;
        errors          = 0;
        status_seen     = '{0, 0, 0};

        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DirRows; r++) begin
            s = dir_text[r];
            text_q.delete();
            for (int i = 0; i < s.len(); i++) begin
                text_q.push_back((i == dir_nul_pos[r]) ? 8'h00 : s[i]);
            end
            typed_res.uuid_high = dir_high[r];
            typed_res.uuid_low  = dir_low[r];
            typed_res.status    = dir_status[r];
            send_text(dir_status[r] != ST_UNTYPED, typed_res);
        end

        typed_res = '0;
        while (chars_sent < RandomChars || results_queued < MinResults) begin
            make_random_text();
            send_text(1'b0, typed_res);
        end
        s_tvalid <= 1'b0;

        while (expected_uuids.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("%0d strings, %0d characters, %0d cycles with the input held off",
                 strings_sent, chars_sent, stall_cycles);
        $display("results checked: %0d parsed, %0d bad length, %0d bad character",
                 status_seen[ST_PARSED], status_seen[ST_BAD_LEN], status_seen[ST_BAD_CHR]);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
